/* rtl/wnst_pkg.sv */
// types and codes shared by the sorted neighbor table
`default_nettype none
package wnst_pkg;

   // entry field widths
   localparam int ID_BITS     = 32;
   localparam int WEIGHT_BITS = 16;

   // request modes
   localparam logic [2:0] MODE_ADD   = 3'd0;
   localparam logic [2:0] MODE_ERASE = 3'd1;
   localparam logic [2:0] MODE_GET   = 3'd2;
   localparam logic [2:0] MODE_TOP   = 3'd3;
   localparam logic [2:0] MODE_THR   = 3'd4;
   localparam logic [2:0] MODE_CLR   = 3'd5;

   // result status codes
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_FULL   = 2'd1;
   localparam logic [1:0] STAT_ABSENT = 2'd2;

   typedef struct packed {
      logic [2:0]             mode;
      logic [ID_BITS-1:0]     neighbor_id;
      logic [WEIGHT_BITS-1:0] weight;
      logic [6:0]             count;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0]     out_id;
      logic [WEIGHT_BITS-1:0] out_weight;
      logic                   found;
      logic                   last;
      logic [1:0]             status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_SHL,
      S_POS,
      S_SHR,
      S_THR,
      S_RESP,
      S_LOUT
   } state_type;

endpackage
`default_nettype wire

/* rtl/weighted_neighbor_sorted_table.sv */
// A lookup or erase of an absent id walks the whole table once; an add or update
// walks the table twice (find then close the gap, find the slot then open it),
// all through the single read port of the entry memory.
// List modes return one item per cycle unless the output stalls, after any threshold walk.
// One request is in work at a time. Reset empties the table (entry count to zero) and
// returns the sequencer to idle; the entry memory itself is not cleared.
`default_nettype none
module weighted_neighbor_sorted_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wnst_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output wnst_pkg::rsp_type     rsp_data
);
   import wnst_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int NW = (CW > 7) ? CW : 7;
   localparam int EW = ID_BITS + WEIGHT_BITS;

   // entry memory, one write and one registered read per cycle
   logic [EW-1:0] mem [TABLE_DEPTH];
   logic [EW-1:0] rd_data_ff;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [EW-1:0] wr_data;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] n_ff, n_in;
   logic          pend_ff, pend_in;
   logic [2:0]    mode_ff, mode_in;
   logic [ID_BITS-1:0]     id_ff, id_in;
   logic [WEIGHT_BITS-1:0] w_ff, w_in;
   logic [ID_BITS-1:0]     res_id_ff, res_id_in;
   logic [WEIGHT_BITS-1:0] res_w_ff, res_w_in;
   logic          res_found_ff, res_found_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic          emit;
   rsp_type       emit_data;

   logic [ID_BITS-1:0]     ent_id;
   logic [WEIGHT_BITS-1:0] ent_w;
   logic accept, out_free, scan_more, id_hit, pos_hit, thr_hit, list_last;
   logic [CW-1:0] top_n, prev_idx;

   assign ent_id    = rd_data_ff[EW-1:WEIGHT_BITS];
   assign ent_w     = rd_data_ff[WEIGHT_BITS-1:0];
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_more = (idx_ff < count_ff);
   assign prev_idx  = CW'(idx_ff - CW'(1));
   assign id_hit    = pend_ff && (ent_id == id_ff);
   assign pos_hit   = pend_ff && !((ent_w > w_ff) || ((ent_w == w_ff) && (ent_id > id_ff)));
   assign thr_hit   = pend_ff && (ent_w < w_ff);
   assign list_last = (CW'(idx_ff + CW'(1)) == n_ff);
   assign top_n     = (NW'(req_data.count) < NW'(count_ff)) ? CW'(req_data.count) : count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.mode)
                  MODE_ADD, MODE_ERASE, MODE_GET: state_in = S_FIND;
                  MODE_TOP: state_in = (top_n == '0) ? S_RESP : S_LOUT;
                  MODE_THR: state_in = S_THR;
                  MODE_CLR: state_in = S_RESP;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_FIND: begin
            if (id_hit) begin
               if (mode_ff == MODE_GET) state_in = S_RESP;
               else if (mode_ff == MODE_ADD && ent_w == w_ff) state_in = S_RESP;
               else state_in = S_SHL;
            end else if (!pend_ff) begin
               if (mode_ff == MODE_ADD && count_ff != CW'(TABLE_DEPTH)) state_in = S_POS;
               else state_in = S_RESP;
            end
         end
         S_SHL: begin
            if (!pend_ff) state_in = (mode_ff == MODE_ADD) ? S_POS : S_RESP;
         end
         S_POS: begin
            if (pos_hit || !pend_ff) state_in = S_SHR;
         end
         S_SHR: begin
            if (!pend_ff) state_in = S_RESP;
         end
         S_THR: begin
            if (thr_hit) state_in = (prev_idx == '0) ? S_RESP : S_LOUT;
            else if (!pend_ff) state_in = (count_ff == '0) ? S_RESP : S_LOUT;
         end
         S_RESP: begin
            if (out_free) state_in = S_IDLE;
         end
         S_LOUT: begin
            if (out_free && list_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      rd_en = 1'b0;
      rd_addr = idx_ff[AW-1:0];
      wr_en = 1'b0;
      wr_addr = idx_ff[AW-1:0];
      wr_data = rd_data_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      n_in = n_ff;
      pend_in = pend_ff;
      mode_in = mode_ff;
      id_in = id_ff;
      w_in = w_ff;
      res_id_in = res_id_ff;
      res_w_in = res_w_ff;
      res_found_in = res_found_ff;
      res_status_in = res_status_ff;
      emit = 1'b0;
      emit_data = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in = req_data.mode;
               id_in = ID_BITS'(req_data.neighbor_id);
               w_in = WEIGHT_BITS'(req_data.weight);
               res_id_in = '0;
               res_w_in = '0;
               res_found_in = 1'b0;
               res_status_in = STAT_OK;
               case (req_data.mode)
                  MODE_ADD, MODE_ERASE, MODE_GET, MODE_THR: begin
                     rd_en = 1'b1;
                     rd_addr = '0;
                     pend_in = (count_ff != '0);
                     idx_in = CW'(1);
                  end
                  MODE_TOP: begin
                     n_in = top_n;
                     rd_en = 1'b1;
                     rd_addr = '0;
                     idx_in = '0;
                  end
                  MODE_CLR: count_in = '0;
                  default: ;
               endcase
            end
         end
         S_FIND: begin
            // walk on; the read of the entry after a hit feeds the gap close
            rd_en = scan_more;
            pend_in = scan_more;
            idx_in = CW'(idx_ff + CW'(1));
            res_id_in = id_ff;
            if (id_hit) begin
               res_found_in = 1'b1;
               res_status_in = STAT_OK;
               res_w_in = (mode_ff == MODE_ADD) ? w_ff : ent_w;
            end else if (!pend_ff) begin
               if (mode_ff == MODE_ADD && count_ff != CW'(TABLE_DEPTH)) begin
                  res_found_in = 1'b1;
                  res_status_in = STAT_OK;
                  res_w_in = w_ff;
                  rd_en = 1'b1;
                  rd_addr = '0;
                  pend_in = (count_ff != '0);
                  idx_in = CW'(1);
               end else begin
                  res_found_in = 1'b0;
                  res_w_in = '0;
                  res_status_in = (mode_ff == MODE_ADD) ? STAT_FULL : STAT_ABSENT;
               end
            end
         end
         S_SHL: begin
            // move each entry one slot down over the removed one
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(idx_ff - CW'(2));
               rd_en = scan_more;
               pend_in = scan_more;
               idx_in = CW'(idx_ff + CW'(1));
            end else begin
               count_in = CW'(count_ff - CW'(1));
               if (mode_ff == MODE_ADD) begin
                  rd_en = 1'b1;
                  rd_addr = '0;
                  pend_in = (count_ff != CW'(1));
                  idx_in = CW'(1);
               end
            end
         end
         S_POS: begin
            rd_en = scan_more;
            pend_in = scan_more;
            idx_in = CW'(idx_ff + CW'(1));
            if (pos_hit || !pend_ff) begin
               pos_in = pos_hit ? prev_idx : count_ff;
               if (count_ff > pos_in) begin
                  rd_en = 1'b1;
                  rd_addr = AW'(count_ff - CW'(1));
                  idx_in = CW'(count_ff - CW'(1));
                  pend_in = 1'b1;
               end else begin
                  rd_en = 1'b0;
                  pend_in = 1'b0;
               end
            end
         end
         S_SHR: begin
            // open a gap at the slot, from the tail down
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(idx_ff + CW'(1));
               if (idx_ff > pos_ff) begin
                  rd_en = 1'b1;
                  rd_addr = AW'(idx_ff - CW'(1));
                  idx_in = CW'(idx_ff - CW'(1));
                  pend_in = 1'b1;
               end else begin
                  pend_in = 1'b0;
               end
            end else begin
               wr_en = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = {id_ff, w_ff};
               count_in = CW'(count_ff + CW'(1));
            end
         end
         S_THR: begin
            rd_en = scan_more;
            pend_in = scan_more;
            idx_in = CW'(idx_ff + CW'(1));
            if (thr_hit || !pend_ff) begin
               n_in = thr_hit ? prev_idx : count_ff;
               rd_en = 1'b1;
               rd_addr = '0;
               idx_in = '0;
            end
         end
         S_RESP: begin
            if (out_free) begin
               emit = 1'b1;
               emit_data.out_id = res_id_ff;
               emit_data.out_weight = res_w_ff;
               emit_data.found = res_found_ff;
               emit_data.last = 1'b1;
               emit_data.status = res_status_ff;
            end
         end
         S_LOUT: begin
            if (out_free) begin
               emit = 1'b1;
               emit_data.out_id = ent_id;
               emit_data.out_weight = ent_w;
               emit_data.found = 1'b1;
               emit_data.last = list_last;
               emit_data.status = STAT_OK;
               if (!list_last) begin
                  rd_en = 1'b1;
                  rd_addr = AW'(idx_ff + CW'(1));
                  idx_in = CW'(idx_ff + CW'(1));
               end
            end
         end
         default: ;
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
      rsp_data_in = emit ? emit_data : rsp_data_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      n_ff <= n_in;
      mode_ff <= mode_in;
      id_ff <= id_in;
      w_ff <= w_in;
      res_id_ff <= res_id_in;
      res_w_ff <= res_w_in;
      res_found_ff <= res_found_in;
      res_status_ff <= res_status_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry count stays within the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   // shifts never read and write the same entry in one cycle
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write of the same entry");

   // gap opening only moves entries inside the table
   a_shr_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHR && pend_ff) |-> (idx_ff < count_ff))
      else $error("shift past table end");

   // count moves by one, or drops to zero on clear
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (count_ff == $past(count_ff) || count_ff == '0 ||
         count_ff == CW'($past(count_ff) + CW'(1)) ||
         count_ff == CW'($past(count_ff) - CW'(1))))
      else $error("entry count jumped");

endmodule
`default_nettype wire
